>>> hdl/gtr_pkg.sv
// Shared types, constants and tables for the gravity torque regressor.
// Holds the arctangent table, the regressor monomial table and the merge term list.
// No dependencies.
package gtr_pkg;

  localparam int JOINTS     = 7;
  localparam int TRIG_JOINTS = 6;
  localparam int TRIG_N     = 12;
  localparam int TRIG_IDX_W = 4;
  localparam int Q_W        = 32;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int TORQUE_W   = 32;
  localparam int ENTRIES    = 12;
  localparam int ROWS       = 6;
  localparam int PROD_W     = 64;
  localparam int SUM_W      = 64;
  localparam int YR_W       = 38;
  localparam int YR_LO_W    = 19;
  localparam int YR_HI_W    = YR_W - YR_LO_W;
  localparam int PART_W     = YR_LO_W + 1 + CFG_W;
  localparam int NUM_MONOS  = 126;
  localparam int MONO_IDX_W = 7;
  localparam int NUM_TERMS  = 12;
  localparam int TERM_IDX_W = 4;
  localparam int GRAV_N     = 3;
  localparam int COEF_N     = 3;

  localparam int CORDIC_ITERS = 24;
  localparam int ITER_W       = 5;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [Q_W-1:0] Q_ONE = 32'sh4000_0000;

  typedef logic signed [Q_W-1:0]      q30_t;
  typedef logic signed [CFG_W-1:0]    cfg_t;
  typedef logic signed [YR_W-1:0]     yr_t;
  typedef logic signed [TORQUE_W-1:0] torque_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRAV_X      = 3'd0,
    REG_GRAV_Y      = 3'd1,
    REG_GRAV_Z      = 3'd2,
    REG_COEF_UPPER  = 3'd3,
    REG_COEF_MIDDLE = 3'd4,
    REG_COEF_WRIST  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {STG_IDLE, STG_RUN, STG_HOLD} stage_t;
  typedef enum logic [1:0] {RS_IDLE, RS_MUL, RS_RND, RS_ACC} regr_state_t;
  typedef enum logic [2:0] {MS_IDLE, MS_LO, MS_LOACC, MS_HIACC, MS_ROUND} merge_state_t;
  typedef enum logic [1:0] {GS_X, GS_Y, GS_Z} grav_sel_t;
  typedef enum logic [1:0] {CS_UPPER, CS_MIDDLE, CS_WRIST} coef_sel_t;

  // Arctangents of 2^-i in phase units (2^32 per turn)
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Factor bits: sines of joints 1..6, then cosines
  localparam logic [TRIG_N-1:0] S1 = 12'h001;
  localparam logic [TRIG_N-1:0] S2 = 12'h002;
  localparam logic [TRIG_N-1:0] S3 = 12'h004;
  localparam logic [TRIG_N-1:0] S4 = 12'h008;
  localparam logic [TRIG_N-1:0] S5 = 12'h010;
  localparam logic [TRIG_N-1:0] S6 = 12'h020;
  localparam logic [TRIG_N-1:0] C1 = 12'h040;
  localparam logic [TRIG_N-1:0] C2 = 12'h080;
  localparam logic [TRIG_N-1:0] C3 = 12'h100;
  localparam logic [TRIG_N-1:0] C4 = 12'h200;
  localparam logic [TRIG_N-1:0] C5 = 12'h400;
  localparam logic [TRIG_N-1:0] C6 = 12'h800;
  localparam logic P = 1'b0;
  localparam logic N = 1'b1;

  typedef struct packed {
    logic [3:0]        entry;
    logic              neg;
    grav_sel_t         grav;
    logic [TRIG_N-1:0] mask;
  } mono_t;

  // Regressor monomials, grouped by entry
  localparam mono_t MONOS [NUM_MONOS] = '{
    '{4'd0,P,GS_X,S1|S2}, '{4'd0,N,GS_Y,C1|S2},
    '{4'd1,P,GS_X,C4|S1|S2}, '{4'd1,N,GS_X,C1|S3|S4}, '{4'd1,N,GS_Y,S1|S3|S4},
    '{4'd1,N,GS_Y,C1|C4|S2}, '{4'd1,P,GS_Y,C1|C2|C3|S4}, '{4'd1,N,GS_X,C2|C3|S1|S4},
    '{4'd2,P,GS_X,C4|C6|S1|S2}, '{4'd2,N,GS_Y,C1|C4|C6|S2}, '{4'd2,N,GS_X,C1|C6|S3|S4},
    '{4'd2,P,GS_X,C1|C3|S5|S6}, '{4'd2,N,GS_Y,C6|S1|S3|S4}, '{4'd2,P,GS_Y,C3|S1|S5|S6},
    '{4'd2,P,GS_Y,C1|C2|C3|C6|S4}, '{4'd2,N,GS_X,C2|C3|C6|S1|S4},
    '{4'd2,P,GS_X,C1|C4|C5|S3|S6}, '{4'd2,P,GS_Y,C1|C2|S3|S5|S6},
    '{4'd2,N,GS_Y,C1|C5|S2|S4|S6}, '{4'd2,P,GS_Y,C4|C5|S1|S3|S6},
    '{4'd2,N,GS_X,C2|S1|S3|S5|S6}, '{4'd2,P,GS_X,C5|S1|S2|S4|S6},
    '{4'd2,N,GS_Y,C1|C2|C3|C4|C5|S6}, '{4'd2,P,GS_X,C2|C3|C4|C5|S1|S6},
    '{4'd3,N,GS_Z,S2}, '{4'd3,N,GS_X,C1|C2}, '{4'd3,N,GS_Y,C2|S1},
    '{4'd4,P,GS_Z,C2|C3|S4}, '{4'd4,N,GS_X,C1|C2|C4}, '{4'd4,N,GS_Y,C2|C4|S1},
    '{4'd4,N,GS_Z,C4|S2}, '{4'd4,N,GS_X,C1|C3|S2|S4}, '{4'd4,N,GS_Y,C3|S1|S2|S4},
    '{4'd5,P,GS_Z,C2|C3|C6|S4}, '{4'd5,N,GS_X,C1|C2|C4|C6}, '{4'd5,N,GS_Y,C2|C4|C6|S1},
    '{4'd5,N,GS_Z,C4|C6|S2}, '{4'd5,P,GS_Z,C2|S3|S5|S6}, '{4'd5,N,GS_Z,C5|S2|S4|S6},
    '{4'd5,N,GS_Y,S1|S2|S3|S5|S6}, '{4'd5,N,GS_Z,C2|C3|C4|C5|S6},
    '{4'd5,N,GS_X,C1|C3|C6|S2|S4}, '{4'd5,N,GS_X,C1|C2|C5|S4|S6},
    '{4'd5,N,GS_Y,C3|C6|S1|S2|S4}, '{4'd5,N,GS_Y,C2|C5|S1|S4|S6},
    '{4'd5,N,GS_X,C1|S2|S3|S5|S6}, '{4'd5,P,GS_X,C1|C3|C4|C5|S2|S6},
    '{4'd5,P,GS_Y,C3|C4|C5|S1|S2|S6},
    '{4'd6,P,GS_Y,C1|C3|S4}, '{4'd6,N,GS_Z,S2|S3|S4}, '{4'd6,N,GS_X,C3|S1|S4},
    '{4'd6,N,GS_X,C1|C2|S3|S4}, '{4'd6,N,GS_Y,C2|S1|S3|S4},
    '{4'd7,P,GS_Y,C1|C3|C6|S4}, '{4'd7,N,GS_X,C3|C6|S1|S4}, '{4'd7,P,GS_Y,C1|S3|S5|S6},
    '{4'd7,N,GS_Z,C6|S2|S3|S4}, '{4'd7,P,GS_Z,C3|S2|S5|S6}, '{4'd7,N,GS_X,S1|S3|S5|S6},
    '{4'd7,N,GS_Y,C1|C3|C4|C5|S6}, '{4'd7,N,GS_X,C1|C2|C6|S3|S4},
    '{4'd7,P,GS_X,C1|C2|C3|S5|S6}, '{4'd7,P,GS_X,C3|C4|C5|S1|S6},
    '{4'd7,N,GS_Y,C2|C6|S1|S3|S4}, '{4'd7,P,GS_Y,C2|C3|S1|S5|S6},
    '{4'd7,P,GS_Z,C4|C5|S2|S3|S6}, '{4'd7,P,GS_X,C1|C2|C4|C5|S3|S6},
    '{4'd7,P,GS_Y,C2|C4|C5|S1|S3|S6},
    '{4'd8,P,GS_X,C1|S2|S4}, '{4'd8,N,GS_Z,C2|S4}, '{4'd8,N,GS_X,C4|S1|S3},
    '{4'd8,P,GS_Y,S1|S2|S4}, '{4'd8,P,GS_Y,C1|C4|S3}, '{4'd8,P,GS_Z,C3|C4|S2},
    '{4'd8,P,GS_X,C1|C2|C3|C4}, '{4'd8,P,GS_Y,C2|C3|C4|S1},
    '{4'd9,P,GS_Y,C1|C4|C6|S3}, '{4'd9,N,GS_Z,C2|C6|S4}, '{4'd9,P,GS_Z,C3|C4|C6|S2},
    '{4'd9,P,GS_Z,C2|C4|C5|S6}, '{4'd9,P,GS_X,C1|C6|S2|S4}, '{4'd9,N,GS_X,C4|C6|S1|S3},
    '{4'd9,P,GS_Y,C6|S1|S2|S4}, '{4'd9,P,GS_X,C1|C2|C3|C4|C6},
    '{4'd9,P,GS_Y,C2|C3|C4|C6|S1}, '{4'd9,N,GS_X,C1|C4|C5|S2|S6},
    '{4'd9,N,GS_Y,C4|C5|S1|S2|S6}, '{4'd9,P,GS_Y,C1|C5|S3|S4|S6},
    '{4'd9,P,GS_Z,C3|C5|S2|S4|S6}, '{4'd9,N,GS_X,C5|S1|S3|S4|S6},
    '{4'd9,P,GS_X,C1|C2|C3|C5|S4|S6}, '{4'd9,P,GS_Y,C2|C3|C5|S1|S4|S6},
    '{4'd10,P,GS_Z,C5|S2|S3|S6}, '{4'd10,N,GS_Z,C2|S4|S5|S6},
    '{4'd10,N,GS_Y,C1|C3|C5|S6}, '{4'd10,P,GS_X,C3|C5|S1|S6},
    '{4'd10,P,GS_X,C1|C2|C5|S3|S6}, '{4'd10,P,GS_Y,C2|C5|S1|S3|S6},
    '{4'd10,P,GS_Y,C1|C4|S3|S5|S6}, '{4'd10,P,GS_Z,C3|C4|S2|S5|S6},
    '{4'd10,P,GS_X,C1|S2|S4|S5|S6}, '{4'd10,N,GS_X,C4|S1|S3|S5|S6},
    '{4'd10,P,GS_Y,S1|S2|S4|S5|S6}, '{4'd10,P,GS_X,C1|C2|C3|C4|S5|S6},
    '{4'd10,P,GS_Y,C2|C3|C4|S1|S5|S6},
    '{4'd11,P,GS_Z,C2|C5|C6|S4}, '{4'd11,N,GS_Y,C1|C3|C6|S5}, '{4'd11,N,GS_Z,C2|C4|S6},
    '{4'd11,P,GS_X,C1|C4|S2|S6}, '{4'd11,P,GS_X,C3|C6|S1|S5}, '{4'd11,P,GS_Y,C4|S1|S2|S6},
    '{4'd11,N,GS_Y,C1|S3|S4|S6}, '{4'd11,N,GS_Z,C3|S2|S4|S6}, '{4'd11,P,GS_Z,C6|S2|S3|S5},
    '{4'd11,P,GS_X,S1|S3|S4|S6}, '{4'd11,N,GS_Y,C1|C4|C5|C6|S3},
    '{4'd11,N,GS_Z,C3|C4|C5|C6|S2}, '{4'd11,N,GS_X,C1|C2|C3|S4|S6},
    '{4'd11,P,GS_X,C1|C2|C6|S3|S5}, '{4'd11,N,GS_X,C1|C5|C6|S2|S4},
    '{4'd11,P,GS_X,C4|C5|C6|S1|S3}, '{4'd11,N,GS_Y,C2|C3|S1|S4|S6},
    '{4'd11,P,GS_Y,C2|C6|S1|S3|S5}, '{4'd11,N,GS_Y,C5|C6|S1|S2|S4},
    '{4'd11,N,GS_X,C1|C2|C3|C4|C5|C6}, '{4'd11,N,GS_Y,C2|C3|C4|C5|C6|S1}
  };

  // Index of the first monomial of an entry (elaboration only)
  function automatic int mono_first(int e);
    int n;
    n = 0;
    for (int k = 0; k < NUM_MONOS; k++) begin
      if (int'(MONOS[k].entry) < e) n++;
    end
    return n;
  endfunction

  typedef struct packed {
    logic [3:0] entry;
    coef_sel_t  coef;
    logic [2:0] row;
    logic       last;
  } term_t;

  // Weighted regressor entries per torque row
  localparam term_t TERMS [NUM_TERMS] = '{
    '{4'd0, CS_UPPER, 3'd0, 1'b0}, '{4'd1, CS_MIDDLE, 3'd0, 1'b0},
    '{4'd2, CS_WRIST, 3'd0, 1'b1},
    '{4'd3, CS_UPPER, 3'd1, 1'b0}, '{4'd4, CS_MIDDLE, 3'd1, 1'b0},
    '{4'd5, CS_WRIST, 3'd1, 1'b1},
    '{4'd6, CS_MIDDLE, 3'd2, 1'b0}, '{4'd7, CS_WRIST, 3'd2, 1'b1},
    '{4'd8, CS_MIDDLE, 3'd3, 1'b0}, '{4'd9, CS_WRIST, 3'd3, 1'b1},
    '{4'd10, CS_WRIST, 3'd4, 1'b1},
    '{4'd11, CS_WRIST, 3'd5, 1'b1}
  };

  // Handoff state of one pipeline stage
  function automatic stage_t stage_next(stage_t st, logic go, logic fin, logic take);
    stage_t nx;
    nx = st;
    case (st)
      STG_IDLE: if (go) nx = STG_RUN;
      STG_RUN:  if (fin) nx = STG_HOLD;
      STG_HOLD: if (take) nx = go ? STG_RUN : STG_IDLE;
      default:  nx = STG_IDLE;
    endcase
    return nx;
  endfunction

endpackage

>>> hdl/gtr_cordic_lane.sv
// One rotation-mode CORDIC lane: joint angle to sine and cosine in Q30.
// Iterates one micro-rotation per cycle. Depends on gtr_pkg.
module gtr_cordic_lane #(
  parameter int ANGLE_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  busy,
  output gtr_pkg::q30_t         sin_q,
  output gtr_pkg::q30_t         cos_q
);
  import gtr_pkg::*;

  localparam int PAD = Q_W - ANGLE_BITS;

  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] x_sh, y_sh, atan_ext, neg_x, neg_y;
  logic [ITER_W-1:0] iter;
  logic run, flip;
  logic [Q_W-1:0] phase, phase_adj;
  logic flip_in;

  // Fold the phase into the right half plane
  always_comb begin
    phase     = {angle, {PAD{1'b0}}};
    flip_in   = phase[Q_W-1] ^ phase[Q_W-2];
    phase_adj = flip_in ? {~phase[Q_W-1], phase[Q_W-2:0]} : phase;
    x_sh      = x >>> iter;
    y_sh      = y >>> iter;
    atan_ext  = {{(CORDIC_W-32){1'b0}}, ATAN_TAB[iter]};
    neg_x     = -x;
    neg_y     = -y;
    sin_q     = flip ? neg_y[Q_W-1:0] : y[Q_W-1:0];
    cos_q     = flip ? neg_x[Q_W-1:0] : x[Q_W-1:0];
    busy      = run;
  end

  // Control: run for a fixed count of iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && iter == ITER_W'(CORDIC_ITERS - 1)) begin
      run <= 1'b0;
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_X0;
      y    <= '0;
      z    <= {{(CORDIC_W-Q_W){phase_adj[Q_W-1]}}, phase_adj};
      flip <= flip_in;
      iter <= '0;
    end else if (run) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - atan_ext;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + atan_ext;
      end
      iter <= iter + 1'b1;
    end
  end

endmodule

>>> hdl/gtr_regr_lane.sv
// One regressor lane: sums the signed, gravity-weighted trig products of one entry.
// Shares one 32x32 multiplier over all factors. Depends on gtr_pkg.
module gtr_regr_lane #(
  parameter int LANE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gtr_pkg::q30_t trig [gtr_pkg::TRIG_N],
  input  gtr_pkg::cfg_t grav [gtr_pkg::GRAV_N],
  output logic          busy,
  output gtr_pkg::yr_t  yr
);
  import gtr_pkg::*;

  localparam int FIRST = mono_first(LANE);
  localparam int LAST  = mono_first(LANE + 1) - 1;

  regr_state_t st, st_next;
  logic [MONO_IDX_W-1:0] idx, idx_inc;
  logic [TRIG_N-1:0] rem;
  q30_t p;
  logic signed [PROD_W-1:0] prod, rnd;
  logic signed [SUM_W-1:0] acc, yr_full;
  mono_t cur;
  logic [TRIG_IDX_W-1:0] fac;
  logic has_fac, at_last;
  cfg_t gv;
  q30_t op;

  // Pick the next factor and the multiplier operand
  always_comb begin
    cur     = MONOS[idx];
    fac     = '0;
    has_fac = 1'b0;
    for (int k = TRIG_N - 1; k >= 0; k--) begin
      if (rem[k]) begin
        fac     = TRIG_IDX_W'(k);
        has_fac = 1'b1;
      end
    end
    case (cur.grav)
      GS_X:    gv = grav[0];
      GS_Y:    gv = grav[1];
      GS_Z:    gv = grav[2];
      default: gv = grav[0];
    endcase
    op      = has_fac ? trig[fac] : {{(Q_W-CFG_W){gv[CFG_W-1]}}, gv};
    at_last = (idx == MONO_IDX_W'(LAST));
    idx_inc = at_last ? idx : idx + 1'b1;
    rnd     = (prod + 64'sd536870912) >>> 30;
    yr_full = (acc + 64'sd2097152) >>> 22;
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      RS_IDLE: if (start) st_next = RS_MUL;
      RS_MUL:  st_next = has_fac ? RS_RND : RS_ACC;
      RS_RND:  st_next = RS_MUL;
      RS_ACC:  st_next = at_last ? RS_IDLE : RS_MUL;
      default: st_next = RS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (st != RS_IDLE);
    yr   = yr_full[YR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) st <= RS_IDLE;
    else     st <= st_next;
  end

  // Product chain and entry accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      idx <= MONO_IDX_W'(FIRST);
      rem <= MONOS[FIRST].mask;
      p   <= Q_ONE;
      acc <= '0;
    end else begin
      case (st)
        RS_MUL: begin
          prod <= p * op;
          if (has_fac) rem <= rem & ~(TRIG_N'(1) << fac);
        end
        RS_RND: p <= rnd[Q_W-1:0];
        RS_ACC: begin
          acc <= cur.neg ? acc - prod : acc + prod;
          idx <= idx_inc;
          rem <= MONOS[idx_inc].mask;
          p   <= Q_ONE;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/gtr_merge.sv
// Merge stage: weights regressor entries by the combined coefficients per row,
// rounds and saturates to 32-bit torques. Depends on gtr_pkg.
module gtr_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gtr_pkg::yr_t     yr_in  [gtr_pkg::ENTRIES],
  input  gtr_pkg::cfg_t    coef   [gtr_pkg::COEF_N],
  output logic             busy,
  output gtr_pkg::torque_t torque [gtr_pkg::ROWS]
);
  import gtr_pkg::*;

  merge_state_t st, st_next;
  yr_t yr [ENTRIES];
  logic [TERM_IDX_W-1:0] term;
  logic signed [PART_W-1:0] prod;
  logic signed [SUM_W-1:0] acc, prod_ext, rnd;
  term_t cur;
  yr_t yv;
  cfg_t cf;
  logic [YR_LO_W-1:0] lo;
  logic signed [YR_HI_W-1:0] hi;
  logic at_end;
  torque_t sat;

  // Operand selection, final rounding and saturation
  always_comb begin
    cur = TERMS[term];
    yv  = yr[cur.entry];
    lo  = yv[YR_LO_W-1:0];
    hi  = yv[YR_W-1:YR_LO_W];
    case (cur.coef)
      CS_UPPER:  cf = coef[0];
      CS_MIDDLE: cf = coef[1];
      CS_WRIST:  cf = coef[2];
      default:   cf = coef[0];
    endcase
    prod_ext = {{(SUM_W-PART_W){prod[PART_W-1]}}, prod};
    at_end   = (term == TERM_IDX_W'(NUM_TERMS - 1));
    rnd      = (acc + 64'sd134217728) >>> 28;
    if (rnd > 64'sd2147483647)       sat = 32'sh7FFF_FFFF;
    else if (rnd < -64'sd2147483648) sat = 32'sh8000_0000;
    else                             sat = rnd[TORQUE_W-1:0];
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      MS_IDLE:  if (start) st_next = MS_LO;
      MS_LO:    st_next = MS_LOACC;
      MS_LOACC: st_next = MS_HIACC;
      MS_HIACC: st_next = cur.last ? MS_ROUND : MS_LO;
      MS_ROUND: st_next = at_end ? MS_IDLE : MS_LO;
      default:  st_next = MS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (st != MS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= MS_IDLE;
    else     st <= st_next;
  end

  // Split multiply: low half unsigned, high half signed and shifted
  always_ff @(posedge clk) begin
    if (start) begin
      yr   <= yr_in;
      term <= '0;
      acc  <= '0;
    end else begin
      case (st)
        MS_LO: prod <= $signed({1'b0, lo}) * cf;
        MS_LOACC: begin
          acc  <= acc + prod_ext;
          prod <= hi * cf;
        end
        MS_HIACC: begin
          acc <= acc + (prod_ext <<< YR_LO_W);
          if (!cur.last) term <= term + 1'b1;
        end
        MS_ROUND: begin
          torque[cur.row] <= sat;
          acc <= '0;
          if (!at_end) term <= term + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/gravity_torque_regressor_7dof.sv
// Gravity torque regressor, seven joints: angles in, saturated gravity torques out.
// Path from an input transfer to m_tvalid: input buffer, CORDIC lanes, regressor lanes
// (the longest is entry 11: 21 monomials, 96 factors on one shared multiplier), merge
// into the output register. The stages overlap, so a new angle set can enter while
// earlier ones are still in flight; the regressor stage is the slowest and sets the rate.
// Synchronous active-high reset clears all handshake state and loads register defaults.
module gravity_torque_regressor_7dof #(
  parameter int ANGLE_BITS = 18,
  localparam int S_W = ((gtr_pkg::JOINTS * ANGLE_BITS + 7) / 8) * 8,
  localparam int M_W = gtr_pkg::JOINTS * gtr_pkg::TORQUE_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [S_W-1:0]                  s_tdata,   // angle_j1 .. angle_j7, zero pad
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [M_W-1:0]                  m_tdata,   // torque_j1 .. torque_j7
  input  logic                            cfg_we,
  input  logic [gtr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gtr_pkg::CFG_W-1:0]       cfg_data
);
  import gtr_pkg::*;

  cfg_t grav [GRAV_N];
  cfg_t coef [COEF_N];
  logic [ANGLE_BITS-1:0] ibuf [TRIG_JOINTS];
  logic ibuf_v;
  stage_t a_st, a_st_next, b_st, b_st_next, c_st, c_st_next;
  logic go_a, go_b, go_c, take_a, take_b, take_c, fin_a, fin_b, fin_c;
  logic [TRIG_JOINTS-1:0] a_busy;
  logic [ENTRIES-1:0] b_busy;
  logic c_busy;
  q30_t trig_a [TRIG_N];
  q30_t trig_b [TRIG_N];
  yr_t yr [ENTRIES];
  torque_t tq_c [ROWS];
  torque_t tq [ROWS];
  logic out_v;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grav[0] <= 24'sd0;
      grav[1] <= 24'sd0;
      grav[2] <= -24'sd642908;
      coef[0] <= 24'sd291226;
      coef[1] <= 24'sd119973;
      coef[2] <= 24'sd65550;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRAV_X:      grav[0] <= cfg_data;
        REG_GRAV_Y:      grav[1] <= cfg_data;
        REG_GRAV_Z:      grav[2] <= cfg_data;
        REG_COEF_UPPER:  coef[0] <= cfg_data;
        REG_COEF_MIDDLE: coef[1] <= cfg_data;
        REG_COEF_WRIST:  coef[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input buffer: hold one transfer until the CORDIC lanes take it
  assign s_tready = !ibuf_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ibuf_v <= 1'b1;
    end else if (go_a) begin
      ibuf_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int j = 0; j < TRIG_JOINTS; j++) begin
        ibuf[j] <= s_tdata[j*ANGLE_BITS +: ANGLE_BITS];
      end
    end
  end

  // Stage handoffs, from the output side back to the input
  always_comb begin
    take_c = (c_st == STG_HOLD) && (!out_v || m_tready);
    go_c   = (b_st == STG_HOLD) && (c_st == STG_IDLE || take_c);
    take_b = go_c;
    go_b   = (a_st == STG_HOLD) && (b_st == STG_IDLE || take_b);
    take_a = go_b;
    go_a   = ibuf_v && (a_st == STG_IDLE || take_a);
    fin_a  = !(|a_busy);
    fin_b  = !(|b_busy);
    fin_c  = !c_busy;
  end

  // Stage next states
  always_comb begin
    a_st_next = stage_next(a_st, go_a, fin_a, take_a);
    b_st_next = stage_next(b_st, go_b, fin_b, take_b);
    c_st_next = stage_next(c_st, go_c, fin_c, take_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_st <= STG_IDLE;
      b_st <= STG_IDLE;
      c_st <= STG_IDLE;
    end else begin
      a_st <= a_st_next;
      b_st <= b_st_next;
      c_st <= c_st_next;
    end
  end

  // CORDIC lanes, one per joint 1..6
  for (genvar j = 0; j < TRIG_JOINTS; j++) begin : g_cordic
    gtr_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clk   (clk),
      .rst   (rst),
      .start (go_a),
      .angle (ibuf[j]),
      .busy  (a_busy[j]),
      .sin_q (trig_a[j]),
      .cos_q (trig_a[j + TRIG_JOINTS])
    );
  end

  // Hold the trig values for the regressor lanes
  always_ff @(posedge clk) begin
    if (go_b) trig_b <= trig_a;
  end

  // Regressor lanes, one per entry
  for (genvar e = 0; e < ENTRIES; e++) begin : g_regr
    gtr_regr_lane #(.LANE(e)) u_regr (
      .clk   (clk),
      .rst   (rst),
      .start (go_b),
      .trig  (trig_b),
      .grav  (grav),
      .busy  (b_busy[e]),
      .yr    (yr[e])
    );
  end

  gtr_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (go_c),
    .yr_in  (yr),
    .coef   (coef),
    .busy   (c_busy),
    .torque (tq_c)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (take_c) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_c) tq <= tq_c;
  end

  assign m_tvalid = out_v;

  for (genvar r = 0; r < ROWS; r++) begin : g_out
    assign m_tdata[r*TORQUE_W +: TORQUE_W] = tq[r];
  end
  assign m_tdata[ROWS*TORQUE_W +: TORQUE_W] = '0;

endmodule

>>> verif/tb_gravity_torque_regressor_7dof.sv
// Testbench for the seven-joint gravity torque regressor: stream driver, stream monitor,
// and a self-contained predictor of the CORDIC, regressor and saturation arithmetic.
// Depends on hdl/gtr_pkg.sv and hdl/gravity_torque_regressor_7dof.sv.
`timescale 1ns / 1ps

module tb_gravity_torque_regressor_7dof;
  import gtr_pkg::*;

  localparam int ABITS = 18;
  localparam int S_W = ((JOINTS * ABITS + 7) / 8) * 8;
  localparam int M_W = JOINTS * TORQUE_W;
  localparam int SETTLE = 400;
  localparam longint LIMIT = 4000000;
  localparam int LONG_HOLD = 3000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [ABITS-1:0] ANG_MAX = 18'h1FFFF;
  localparam logic [ABITS-1:0] ANG_MIN = 18'h20000;
  localparam logic [ABITS-1:0] ANG_HALF = 18'h10000;
  localparam logic [ABITS-1:0] ANG_NHALF = 18'h30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  gravity_torque_regressor_7dof #(.ANGLE_BITS(ABITS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copy used by the predictor
  longint gx, gy, gz, k_upper, k_middle, k_wrist;

  logic [S_W-1:0] angle_sets[$];
  logic [M_W-1:0] torque_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_sat = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit in_acc = 1'b0;
  int gap_cnt = 0;
  int hold_cnt = 0;
  longint cycles = 0;

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Rotate to the angle, Q30 sine and cosine, folding the middle half-turn
  function automatic void rotate(logic [ABITS-1:0] ang, output longint sn, output longint cs);
    logic [31:0] ph;
    bit flip;
    longint x, y, z, nx;
    ph = {ang, 14'b0};
    flip = ph[31] ^ ph[30];
    if (flip) ph = ph - 32'h8000_0000;
    z = longint'($signed(ph));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic logic [31:0] round_sat(longint acc);
    longint t;
    t = (acc + (64'sd1 <<< 27)) >>> 28;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic logic [M_W-1:0] gravity_torques(logic [S_W-1:0] d);
    longint trig[TRIG_N];
    longint acc[ENTRIES];
    longint yr[ENTRIES];
    longint g[GRAV_N];
    longint p;
    mono_t m;
    logic [M_W-1:0] r;
    for (int j = 0; j < TRIG_JOINTS; j++)
      rotate(d[j*ABITS +: ABITS], trig[j], trig[j+TRIG_JOINTS]);
    g[0] = gx; g[1] = gy; g[2] = gz;
    for (int e = 0; e < ENTRIES; e++) acc[e] = 0;
    for (int k = 0; k < NUM_MONOS; k++) begin
      m = MONOS[k];
      p = 64'sd1 <<< 30;
      for (int j = 0; j < TRIG_N; j++)
        if (m.mask[j]) p = qmul(p, trig[j]);
      p = p * g[int'(m.grav)];
      acc[m.entry] += m.neg ? -p : p;
    end
    for (int e = 0; e < ENTRIES; e++) yr[e] = (acc[e] + (64'sd1 <<< 21)) >>> 22;
    r = '0;
    r[0*32 +: 32] = round_sat(yr[0] * k_upper + yr[1] * k_middle + yr[2] * k_wrist);
    r[1*32 +: 32] = round_sat(yr[3] * k_upper + yr[4] * k_middle + yr[5] * k_wrist);
    r[2*32 +: 32] = round_sat(yr[6] * k_middle + yr[7] * k_wrist);
    r[3*32 +: 32] = round_sat(yr[8] * k_middle + yr[9] * k_wrist);
    r[4*32 +: 32] = round_sat(yr[10] * k_wrist);
    r[5*32 +: 32] = round_sat(yr[11] * k_wrist);
    return r;
  endfunction

  task automatic report(string what, int field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s item %0d torque_j%0d: got %0d want %0d", what, n_seen, field + 1,
             $signed(got), $signed(want));
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Input monitor: predict on every accepted transfer
  always @(posedge clk) begin
    in_acc <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      torque_due.insert(torque_due.size(), gravity_torques(s_tdata));
      n_sent <= n_sent + 1;
    end
  end

  // Output monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    logic [M_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (torque_due.size() == 0) begin
        report("unexpected", 0, m_tdata[31:0], 32'd0);
      end else begin
        want = torque_due.pop_front();
        for (int j = 0; j < JOINTS; j++)
          if (m_tdata[j*32 +: 32] !== want[j*32 +: 32])
            report("field", j, m_tdata[j*32 +: 32], want[j*32 +: 32]);
        for (int j = 0; j < ROWS; j++)
          if (want[j*32 +: 32] == 32'h7FFF_FFFF || want[j*32 +: 32] == 32'h8000_0000)
            n_sat++;
      end
      n_seen++;
    end
  end

  // Driver: present queued angle sets, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_acc) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_tvalid <= 1'b0;
      end else if (angle_sets.size() > 0) begin
        s_tdata <= angle_sets.pop_front();
        s_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) gap_cnt <= $urandom_range(1, 14);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(0, 13);
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    longint v;
    v = longint'($signed(val));
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRAV_X:      gx = v;
      REG_GRAV_Y:      gy = v;
      REG_GRAV_Z:      gz = v;
      REG_COEF_UPPER:  k_upper = v;
      REG_COEF_MIDDLE: k_middle = v;
      REG_COEF_WRIST:  k_wrist = v;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b, logic [CFG_W-1:0] c,
                           logic [CFG_W-1:0] d, logic [CFG_W-1:0] e, logic [CFG_W-1:0] f);
    write_reg(REG_GRAV_X, a);
    write_reg(REG_GRAV_Y, b);
    write_reg(REG_GRAV_Z, c);
    write_reg(REG_COEF_UPPER, d);
    write_reg(REG_COEF_MIDDLE, e);
    write_reg(REG_COEF_WRIST, f);
  endtask

  task automatic drain();
    wait (angle_sets.size() == 0 && !s_tvalid && torque_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Append one angle set to the pending queue
  task automatic add_set(logic [S_W-1:0] d);
    angle_sets.insert(angle_sets.size(), d);
  endtask

  function automatic logic [S_W-1:0] same_angles(logic [ABITS-1:0] a);
    logic [S_W-1:0] d;
    d = '0;
    for (int j = 0; j < JOINTS; j++) d[j*ABITS +: ABITS] = a;
    return d;
  endfunction

  // Random angle set; some joints land near the quadrant edges
  function automatic logic [S_W-1:0] random_angles();
    logic [S_W-1:0] d;
    logic [ABITS-1:0] a;
    d = '0;
    for (int j = 0; j < JOINTS; j++) begin
      a = ABITS'($urandom);
      if ($urandom_range(0, 7) == 0)
        a = {a[17:16], 16'h0} + ABITS'($urandom_range(0, 6)) - ABITS'(3);
      d[j*ABITS +: ABITS] = a;
    end
    return d;
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) add_set(random_angles());
  endtask

  initial begin
    logic [S_W-1:0] d;
    gx = 0; gy = 0; gz = -642908;
    k_upper = 291226; k_middle = 119973; k_wrist = 65550;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets under reset defaults
    add_set('0);
    add_set(same_angles(ANG_MAX));
    add_set(same_angles(ANG_MIN));
    add_set(same_angles(ANG_HALF));
    add_set(same_angles(ANG_NHALF));
    add_set(same_angles(ANG_HALF - ABITS'(1)));
    add_set(same_angles(ANG_NHALF - ABITS'(1)));
    add_set(same_angles(18'h00001));
    add_set(same_angles(18'h3FFFF));
    for (int j = 0; j < JOINTS; j++) begin
      d = '0;
      d[j*ABITS +: ABITS] = ANG_HALF;
      add_set(d);
    end
    d = '0;
    for (int j = 0; j < JOINTS; j++) d[j*ABITS +: ABITS] = j[0] ? ANG_MAX : ANG_MIN;
    add_set(d);
    random_items(150);
    drain();

    // Random registers; the spare indexes must not disturb anything
    write_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
              CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    write_reg(REG_SPARE_6, CFG_W'($urandom));
    write_reg(REG_SPARE_7, CFG_W'($urandom));
    random_items(300);
    // Long receiver hold-off while the sender keeps offering
    repeat (200) @(posedge clk);
    hold_req = 1'b1;
    drain();

    // Largest positive registers, then the most negative, then a mix of extremes
    write_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_set(same_angles(ANG_HALF));
    random_items(250);
    drain();
    write_all(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    add_set(same_angles(ANG_NHALF));
    random_items(250);
    drain();
    write_all(24'h7FFFFF, 24'h800000, 24'h000000, 24'h800000, 24'h7FFFFF, 24'h000001);
    random_items(250);
    drain();

    // Several random settings; the last stretch runs with no idling
    for (int ph = 0; ph < 3; ph++) begin
      write_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      if (ph == 2) quiet = 1'b1;
      random_items(260);
      drain();
    end

    errors += torque_due.size();
    $display("Covered %0d angle sets over eight register settings, %0d torques saturated.",
             n_sent, n_sat);
    $display("Results checked: %0d, mismatches: %0d.", n_seen, errors);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> gravity_torque_regressor_7dof.f
hdl/gtr_pkg.sv
hdl/gtr_cordic_lane.sv
hdl/gtr_regr_lane.sv
hdl/gtr_merge.sv
hdl/gravity_torque_regressor_7dof.sv
verif/tb_gravity_torque_regressor_7dof.sv
